/* rtl/nirfd_pkg.sv */
// Package for the NEC infrared frame decoder: phase type, pulse windows,
// register map and the item and result structs shared by the modules.
// No dependencies.
package nirfd_pkg;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD_LOW,
		PH_LEAD_HIGH,
		PH_BIT_LOW,
		PH_BIT_HIGH
	} phase_t;

	localparam logic CMD_EDGE  = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	localparam int unsigned LEAD_LOW_MIN_US  = 7500;
	localparam int unsigned LEAD_LOW_MAX_US  = 10500;
	localparam int unsigned LEAD_HIGH_MIN_US = 3800;
	localparam int unsigned LEAD_HIGH_MAX_US = 5200;
	localparam int unsigned REPEAT_MIN_US    = 1800;
	localparam int unsigned REPEAT_MAX_US    = 2700;
	localparam int unsigned BIT_SHORT_MIN_US = 300;
	localparam int unsigned BIT_SHORT_MAX_US = 900;
	localparam int unsigned BIT_ONE_MIN_US   = 1300;
	localparam int unsigned BIT_ONE_MAX_US   = 2000;

	localparam int unsigned FRAME_BITS = 32;
	localparam int unsigned TIMEOUT_US_MAX = 65535;
	localparam int unsigned TIMEOUT_RESET_US = 30000;

	localparam int unsigned APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT = 3'd0;

	typedef struct packed {
		logic        cmd;
		logic        level;
		logic [31:0] now_ticks;
	} edge_item_t;

	typedef struct packed {
		logic [7:0] address;
		logic [7:0] command;
		logic       is_repeat;
	} frame_res_t;

endpackage

/* rtl/nirfd_if.sv */
// Handshake channels of the NEC infrared frame decoder: edge words in,
// frame words out. No dependencies.
interface nirfd_edge_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic        level;
	logic [31:0] now_ticks;

	modport source (output valid, cmd, level, now_ticks, input ready);
	modport sink (input valid, cmd, level, now_ticks, output ready);
endinterface

interface nirfd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] address;
	logic [7:0] command;
	logic       is_repeat;

	modport source (output valid, address, command, is_repeat, input ready);
	modport sink (input valid, address, command, is_repeat, output ready);
endinterface

/* rtl/nec_ir_frame_decoder_top.sv */
// Top level of the NEC infrared frame decoder: edge word register, decoder
// core, frame word register and APB registers. Depends on nirfd_pkg,
// nirfd_if, nirfd_cfg and nirfd_core.
//
//   channel  dir  handshake      payload
//   edges    in   valid/ready    cmd, level, now_ticks
//   frames   out  valid/ready    address, command, is_repeat
//   apb      in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// One edge word per cycle unless a frame word is stalled; the core decodes the word in
// the edge word register and a hit is registered in the frame word register.
// A frame word held against frames.ready stalls the edge register, and edges.ready
// drops only while an edge word also waits there. Reset puts the decoder idle and
// timeout_us at 30000.
module nec_ir_frame_decoder_top
	import nirfd_pkg::*;
#(
	parameter int unsigned TICKS_PER_US = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	nirfd_edge_if.sink            edges,
	nirfd_frame_if.source         frames,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int unsigned LIMIT_W = $clog2((TIMEOUT_US_MAX + 1) * TICKS_PER_US + 1);

	logic               valid_s1;
	edge_item_t         item_s1;
	logic               valid_s2;
	frame_res_t         res_s2;
	logic               advance;
	logic               step;
	logic               hit;
	frame_res_t         res;
	logic [LIMIT_W-1:0] limit;

	assign advance     = !valid_s2 || frames.ready;
	assign edges.ready = !valid_s1 || advance;
	assign step        = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (edges.ready)
				valid_s1 <= edges.valid;
			if (advance)
				valid_s2 <= step && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (edges.valid && edges.ready)
			item_s1 <= '{cmd: edges.cmd, level: edges.level, now_ticks: edges.now_ticks};
		if (step && hit)
			res_s2 <= res;
	end

	assign frames.valid     = valid_s2;
	assign frames.address   = res_s2.address;
	assign frames.command   = res_s2.command;
	assign frames.is_repeat = res_s2.is_repeat;

	nirfd_cfg #(
		.TICKS_PER_US (TICKS_PER_US),
		.LIMIT_W      (LIMIT_W)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.limit   (limit)
	);

	nirfd_core #(
		.TICKS_PER_US (TICKS_PER_US),
		.LIMIT_W      (LIMIT_W)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.limit  (limit),
		.hit    (hit),
		.res    (res)
	);

endmodule

/* rtl/nirfd_cfg.sv */
// APB register block of the NEC infrared frame decoder: timeout_us and the
// derived timeout limit in ticks. Depends on nirfd_pkg.
module nirfd_cfg
	import nirfd_pkg::*;
#(
	parameter int unsigned TICKS_PER_US = 16,
	parameter int unsigned LIMIT_W = $clog2((TIMEOUT_US_MAX + 1) * TICKS_PER_US + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output logic [LIMIT_W-1:0]    limit
);

	localparam logic [LIMIT_W-1:0] TPU = LIMIT_W'(TICKS_PER_US);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET =
		LIMIT_W'((TIMEOUT_RESET_US + 1) * TICKS_PER_US);

	logic [15:0]        timeout_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               wr_en;

	assign wr_en  = psel && penable && pwrite && (paddr == ADDR_TIMEOUT);
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_TIMEOUT) ? {16'd0, timeout_q} : 32'd0;
	assign limit  = limit_q;

	// limit is the first tick count whose microsecond value exceeds timeout_us
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'(TIMEOUT_RESET_US);
			limit_q   <= LIMIT_RESET;
		end else if (wr_en) begin
			timeout_q <= pwdata[15:0];
			limit_q   <= (LIMIT_W'(pwdata[15:0]) + LIMIT_W'(1)) * TPU;
		end
	end

endmodule

/* rtl/nirfd_core.sv */
// Phase machine and bit collector of the NEC infrared frame decoder; pulse
// windows are compared in ticks. Depends on nirfd_pkg.
module nirfd_core
	import nirfd_pkg::*;
#(
	parameter int unsigned TICKS_PER_US = 16,
	parameter int unsigned LIMIT_W = $clog2((TIMEOUT_US_MAX + 1) * TICKS_PER_US + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  edge_item_t         item,
	input  logic [LIMIT_W-1:0] limit,
	output logic               hit,
	output frame_res_t         res
);

	// window [lo, hi] us holds ticks in [lo*T, (hi+1)*T)
	localparam logic [31:0] LL_LO = 32'(LEAD_LOW_MIN_US * TICKS_PER_US);
	localparam logic [31:0] LL_HI = 32'((LEAD_LOW_MAX_US + 1) * TICKS_PER_US);
	localparam logic [31:0] LH_LO = 32'(LEAD_HIGH_MIN_US * TICKS_PER_US);
	localparam logic [31:0] LH_HI = 32'((LEAD_HIGH_MAX_US + 1) * TICKS_PER_US);
	localparam logic [31:0] RP_LO = 32'(REPEAT_MIN_US * TICKS_PER_US);
	localparam logic [31:0] RP_HI = 32'((REPEAT_MAX_US + 1) * TICKS_PER_US);
	localparam logic [31:0] BS_LO = 32'(BIT_SHORT_MIN_US * TICKS_PER_US);
	localparam logic [31:0] BS_HI = 32'((BIT_SHORT_MAX_US + 1) * TICKS_PER_US);
	localparam logic [31:0] B1_LO = 32'(BIT_ONE_MIN_US * TICKS_PER_US);
	localparam logic [31:0] B1_HI = 32'((BIT_ONE_MAX_US + 1) * TICKS_PER_US);

	phase_t      phase_q, phase_d;
	logic [31:0] last_edge_q, last_edge_d;
	logic [31:0] shift_q, shift_d;
	logic [5:0]  bit_cnt_q, bit_cnt_d;
	logic        have_cmd_q, have_cmd_d;
	logic [7:0]  held_addr_q, held_addr_d;
	logic [7:0]  held_cmd_q, held_cmd_d;

	logic [31:0] dt;
	logic        win_ll, win_lh, win_rp, win_bs, win_b1;
	logic        timed_out, ignore, take_edge;
	logic [31:0] shift_new;
	logic [5:0]  cnt_inc;
	logic        frame_done, frame_ok;

	assign dt        = item.now_ticks - last_edge_q;
	assign win_ll    = (dt >= LL_LO) && (dt < LL_HI);
	assign win_lh    = (dt >= LH_LO) && (dt < LH_HI);
	assign win_rp    = (dt >= RP_LO) && (dt < RP_HI);
	assign win_bs    = (dt >= BS_LO) && (dt < BS_HI);
	assign win_b1    = (dt >= B1_LO) && (dt < B1_HI);
	assign timed_out = dt >= 32'(limit);
	assign ignore    = (phase_q == PH_IDLE) && item.level;
	assign take_edge = step && (item.cmd == CMD_EDGE) && !ignore;

	assign shift_new  = shift_q | (win_b1 ? (32'd1 << bit_cnt_q[4:0]) : 32'd0);
	assign cnt_inc    = bit_cnt_q + 6'd1;
	assign frame_done = cnt_inc >= 6'(FRAME_BITS);
	assign frame_ok   = ((shift_new[7:0] & shift_new[15:8]) == 8'd0)
		|| (~shift_new[23:16] == shift_new[31:24]);

	always_comb begin
		phase_d = phase_q;
		if (step && (item.cmd == CMD_CHECK)) begin
			if ((phase_q != PH_IDLE) && timed_out)
				phase_d = PH_IDLE;
		end else if (take_edge) begin
			case (phase_q)
				PH_IDLE: phase_d = PH_LEAD_LOW;
				PH_LEAD_LOW: begin
					if (item.level)
						phase_d = win_ll ? PH_LEAD_HIGH : PH_IDLE;
				end
				PH_LEAD_HIGH: begin
					if (!item.level)
						phase_d = win_lh ? PH_BIT_LOW : PH_IDLE;
				end
				PH_BIT_LOW: begin
					if (item.level)
						phase_d = win_bs ? PH_BIT_HIGH : PH_IDLE;
				end
				PH_BIT_HIGH: begin
					if (!item.level) begin
						if (!(win_b1 || win_bs) || frame_done)
							phase_d = PH_IDLE;
						else
							phase_d = PH_BIT_LOW;
					end
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	always_comb begin
		last_edge_d = last_edge_q;
		shift_d     = shift_q;
		bit_cnt_d   = bit_cnt_q;
		have_cmd_d  = have_cmd_q;
		held_addr_d = held_addr_q;
		held_cmd_d  = held_cmd_q;
		hit         = 1'b0;
		res         = '{address: held_addr_q, command: held_cmd_q, is_repeat: 1'b1};
		if (take_edge) begin
			last_edge_d = item.now_ticks;
			case (phase_q)
				PH_IDLE: begin
					shift_d   = 32'd0;
					bit_cnt_d = 6'd0;
				end
				PH_LEAD_HIGH: begin
					if (!item.level && !win_lh && win_rp && have_cmd_q)
						hit = 1'b1;
				end
				PH_BIT_HIGH: begin
					if (!item.level && (win_b1 || win_bs)) begin
						shift_d   = shift_new;
						bit_cnt_d = cnt_inc;
						if (frame_done && frame_ok) begin
							have_cmd_d  = 1'b1;
							held_addr_d = shift_new[7:0];
							held_cmd_d  = shift_new[23:16];
							hit         = 1'b1;
							res = '{address: shift_new[7:0], command: shift_new[23:16],
								is_repeat: 1'b0};
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			last_edge_q <= 32'd0;
			shift_q     <= 32'd0;
			bit_cnt_q   <= 6'd0;
			have_cmd_q  <= 1'b0;
			held_addr_q <= 8'd0;
			held_cmd_q  <= 8'd0;
		end else begin
			phase_q     <= phase_d;
			last_edge_q <= last_edge_d;
			shift_q     <= shift_d;
			bit_cnt_q   <= bit_cnt_d;
			have_cmd_q  <= have_cmd_d;
			held_addr_q <= held_addr_d;
			held_cmd_q  <= held_cmd_d;
		end
	end

endmodule

/* rtl/nirfd_checker.sv */
// Port checker for the NEC infrared frame decoder and its bind to the top
// level. Depends on nec_ir_frame_decoder_top.
module nirfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_address,
	input logic [7:0] out_command,
	input logic       out_is_repeat
);

	logic in_acc;
	logic out_stall;

	assign in_acc    = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> out_valid)
		else $error("frame word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_stall |=> ($stable(out_address) && $stable(out_command)
			&& $stable(out_is_repeat)))
		else $error("frame word changed while stalled");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_stall)
		else $error("edge channel blocked without frame back-pressure");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!in_acc && !out_stall) ##1 (!in_acc && !out_stall) |=> !out_valid)
		else $error("frame word without a pending edge word");

endmodule

bind nec_ir_frame_decoder_top nirfd_checker u_nirfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (edges.valid),
	.in_ready      (edges.ready),
	.out_valid     (frames.valid),
	.out_ready     (frames.ready),
	.out_address   (frames.address),
	.out_command   (frames.command),
	.out_is_repeat (frames.is_repeat)
);

/* test/nec_ir_frame_decoder_top_tb.sv */
// Testbench for nec_ir_frame_decoder_top: drives timestamped edge and check
// words, predicts every frame word and checks each one field by field.
// Depends on nirfd_pkg, nirfd_if and the decoder RTL.
`timescale 1ns / 1ps

module nec_ir_frame_decoder_top_tb;
	import nirfd_pkg::*;

	localparam int unsigned TPU = 16;
	localparam int unsigned ITEMS = 1900;
	localparam int unsigned PHASE_ITEMS = 400;
	localparam int unsigned SETTLE = 4;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int SCRIPT_LEN = 26;
	localparam int BREAK_NONE = 0;
	localparam int BREAK_WIDTH = 1;
	localparam int BREAK_STALL = 2;
	localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

	typedef struct packed {
		logic        cmd;
		logic        level;
		logic [31:0] delta;
		logic        silent;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	nirfd_edge_if  edges_ch ();
	nirfd_frame_if frames_ch ();

	nec_ir_frame_decoder_top #(.TICKS_PER_US(TPU)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.edges   (edges_ch),
		.frames  (frames_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	phase_t      dec_phase;
	logic [31:0] dec_last_edge;
	logic [31:0] dec_shift;
	logic [5:0]  dec_count;
	logic        dec_have;
	logic [7:0]  dec_addr;
	logic [7:0]  dec_cmd;
	logic [15:0] dec_timeout;

	frame_res_t  frames_due [$];
	frame_res_t  due_word;
	logic [31:0] stamp;
	int unsigned work_items = 0;
	int unsigned fails = 0;
	int unsigned cycles = 0;
	bit          calm = 1'b0;

	script_row_t script [SCRIPT_LEN] = '{
		'{CMD_EDGE,  1'b1, 32'd1, 1'b1},
		'{CMD_CHECK, 1'b0, 32'd1, 1'b1},
		'{CMD_EDGE,  1'b0, 32'd16, 1'b0},
		'{CMD_EDGE,  1'b0, 32'd8, 1'b1},
		'{CMD_CHECK, 1'b1, TIMEOUT_RESET_US * TPU + TPU - 1, 1'b1},
		'{CMD_CHECK, 1'b0, 32'd1, 1'b1},
		'{CMD_EDGE,  1'b1, 32'd5, 1'b1},
		'{CMD_EDGE,  1'b0, 32'd100, 1'b0},
		'{CMD_EDGE,  1'b1, LEAD_LOW_MIN_US * TPU, 1'b0},
		'{CMD_EDGE,  1'b1, 32'd40, 1'b1},
		'{CMD_EDGE,  1'b0, 2250 * TPU, 1'b1},
		'{CMD_EDGE,  1'b0, 32'd1000, 1'b0},
		'{CMD_EDGE,  1'b1, LEAD_LOW_MAX_US * TPU + TPU - 1, 1'b0},
		'{CMD_EDGE,  1'b0, LEAD_HIGH_MIN_US * TPU, 1'b0},
		'{CMD_EDGE,  1'b1, BIT_SHORT_MIN_US * TPU, 1'b0},
		'{CMD_EDGE,  1'b1, 32'd7, 1'b1},
		'{CMD_EDGE,  1'b0, BIT_ONE_MAX_US * TPU + TPU - 1, 1'b0},
		'{CMD_EDGE,  1'b1, BIT_SHORT_MAX_US * TPU + TPU - 1, 1'b0},
		'{CMD_EDGE,  1'b0, BIT_SHORT_MIN_US * TPU - 1, 1'b1},
		'{CMD_EDGE,  1'b0, 32'd50, 1'b0},
		'{CMD_EDGE,  1'b1, LEAD_LOW_MIN_US * TPU - 1, 1'b1},
		'{CMD_EDGE,  1'b0, 32'd50, 1'b0},
		'{CMD_EDGE,  1'b1, (LEAD_LOW_MAX_US + 1) * TPU, 1'b1},
		'{CMD_EDGE,  1'b0, 32'd50, 1'b0},
		'{CMD_EDGE,  1'b1, 9000 * TPU, 1'b0},
		'{CMD_EDGE,  1'b0, (LEAD_HIGH_MAX_US + 1) * TPU, 1'b1}
	};

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic bit in_win(input logic [31:0] v, input int unsigned lo, hi);
		return v >= lo && v <= hi;
	endfunction

	function automatic bit decode_edge(input edge_item_t it, output frame_res_t word);
		logic [31:0] us;
		logic [7:0]  a, ai, c, ci;
		word = '0;
		us = (it.now_ticks - dec_last_edge) / TPU;
		if (it.cmd == CMD_CHECK) begin
			if (dec_phase != PH_IDLE && us > dec_timeout)
				dec_phase = PH_IDLE;
			return 1'b0;
		end
		if (dec_phase == PH_IDLE && it.level)
			return 1'b0;
		dec_last_edge = it.now_ticks;
		case (dec_phase)
		PH_IDLE: begin
			dec_phase = PH_LEAD_LOW;
			dec_shift = '0;
			dec_count = '0;
		end
		PH_LEAD_LOW:
			if (it.level)
				dec_phase = in_win(us, LEAD_LOW_MIN_US, LEAD_LOW_MAX_US) ? PH_LEAD_HIGH : PH_IDLE;
		PH_LEAD_HIGH:
			if (!it.level) begin
				if (in_win(us, LEAD_HIGH_MIN_US, LEAD_HIGH_MAX_US)) begin
					dec_phase = PH_BIT_LOW;
				end else begin
					dec_phase = PH_IDLE;
					if (in_win(us, REPEAT_MIN_US, REPEAT_MAX_US) && dec_have) begin
						word = '{dec_addr, dec_cmd, 1'b1};
						return 1'b1;
					end
				end
			end
		PH_BIT_LOW:
			if (it.level)
				dec_phase = in_win(us, BIT_SHORT_MIN_US, BIT_SHORT_MAX_US) ? PH_BIT_HIGH : PH_IDLE;
		PH_BIT_HIGH:
			if (!it.level) begin
				if (in_win(us, BIT_ONE_MIN_US, BIT_ONE_MAX_US)) begin
					dec_shift[dec_count[4:0]] = 1'b1;
				end else if (!in_win(us, BIT_SHORT_MIN_US, BIT_SHORT_MAX_US)) begin
					dec_phase = PH_IDLE;
					return 1'b0;
				end
				dec_count = dec_count + 6'd1;
				if (dec_count >= FRAME_BITS) begin
					{ci, c, ai, a} = dec_shift;
					dec_phase = PH_IDLE;
					if ((a & ai) == 8'h00 || ~c == ci) begin
						dec_addr = a;
						dec_cmd = c;
						dec_have = 1'b1;
						word = '{a, c, 1'b0};
						return 1'b1;
					end
				end else begin
					dec_phase = PH_BIT_LOW;
				end
			end
		default:
			dec_phase = PH_IDLE;
		endcase
		return 1'b0;
	endfunction

	function automatic int unsigned pick_us(input int unsigned lo, hi, input bit bad);
		int unsigned r;
		r = $urandom_range(0, 7);
		if (bad)
			return r[0] ? $urandom_range(0, lo - 1) : hi + 1 + $urandom_range(0, 4000);
		if (r == 0)
			return lo;
		if (r == 1)
			return hi;
		return $urandom_range(lo, hi);
	endfunction

	function automatic logic [31:0] frame_bits();
		logic [7:0] a, c;
		a = 8'($urandom);
		c = 8'($urandom);
		case ($urandom_range(0, 4))
		0, 1: return {~c, c, ~a, a};
		2: return {8'($urandom), c, 8'($urandom) & ~a, a};
		3: return {~c, c, 8'($urandom) | a, a};
		default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic c, input logic lv, input logic [31:0] tk,
		input logic silent);
		edge_item_t it;
		frame_res_t word;
		bit made;
		while (!calm && $urandom_range(0, 99) < 16) begin
			edges_ch.valid <= 1'b0;
			@(negedge clk);
		end
		edges_ch.valid <= 1'b1;
		edges_ch.cmd <= c;
		edges_ch.level <= lv;
		edges_ch.now_ticks <= tk;
		do @(posedge clk); while (!edges_ch.ready);
		it = '{c, lv, tk};
		if (c == CMD_CHECK ? dec_phase != PH_IDLE : !(dec_phase == PH_IDLE && lv))
			work_items++;
		made = decode_edge(it, word);
		if (silent)
			made = 1'b0;
		if (made)
			frames_due.push_back(word);
		@(negedge clk);
	endtask

	task automatic pulse(input logic lv, input int unsigned lo, hi, input bit bad);
		logic [31:0] probe;
		if ($urandom_range(0, 49) == 0) begin
			stamp = stamp + $urandom_range(1, 50 * TPU);
			send_word(CMD_EDGE, !lv, stamp, 1'b0);
		end
		if ($urandom_range(0, 149) == 0) begin
			probe = stamp + $urandom_range(0, 1000 * TPU);
			send_word(CMD_CHECK, 1'($urandom_range(0, 1)), probe, 1'b0);
		end
		stamp = stamp + pick_us(lo, hi, bad) * TPU + $urandom_range(0, TPU - 1);
		send_word(CMD_EDGE, lv, stamp, 1'b0);
	endtask

	task automatic start_frame();
		if (dec_phase != PH_IDLE)
			send_word(CMD_CHECK, 1'($urandom_range(0, 1)),
				dec_last_edge + (TIMEOUT_US_MAX + 1) * TPU + $urandom_range(0, TPU - 1), 1'b0);
		stamp = stamp + $urandom_range(0, 20000 * TPU);
		send_word(CMD_EDGE, 1'b0, stamp, 1'b0);
	endtask

	task automatic send_frame(input logic [31:0] bits, input int how, input int at);
		int j;
		int unsigned lo, hi;
		logic [31:0] probe;
		start_frame();
		for (j = 0; j < 66; j++) begin
			if (j == at && how == BREAK_STALL) begin
				probe = dec_last_edge + TPU * (32'(dec_timeout)
					+ ($urandom_range(0, 3) == 0 ? 0 : 1 + $urandom_range(0, 500)))
					+ $urandom_range(0, TPU - 1);
				send_word(CMD_CHECK, 1'($urandom_range(0, 1)), probe, 1'b0);
				return;
			end
			if (j == 0) begin
				lo = LEAD_LOW_MIN_US;
				hi = LEAD_LOW_MAX_US;
			end else if (j == 1) begin
				lo = LEAD_HIGH_MIN_US;
				hi = LEAD_HIGH_MAX_US;
			end else if (!j[0] || !bits[(j - 3) / 2]) begin
				lo = BIT_SHORT_MIN_US;
				hi = BIT_SHORT_MAX_US;
			end else begin
				lo = BIT_ONE_MIN_US;
				hi = BIT_ONE_MAX_US;
			end
			pulse(!j[0], lo, hi, j == at && how == BREAK_WIDTH);
			if (j == at && how == BREAK_WIDTH)
				return;
		end
	endtask

	task automatic apb_xfer(input logic wr, input logic [APB_ADDR_W-1:0] a,
		input logic [31:0] wd, output logic [31:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= wd;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic read_timeout();
		logic [31:0] rd;
		apb_xfer(1'b0, ADDR_TIMEOUT, 32'd0, rd);
		if (rd[15:0] !== dec_timeout) begin
			$error("timeout_us: expected %0d, got %0d", dec_timeout, rd[15:0]);
			fails++;
		end
	endtask

	task automatic set_timeout(input logic [15:0] v);
		logic [31:0] rd;
		apb_xfer(1'b1, ADDR_TIMEOUT, {16'h0, v}, rd);
		dec_timeout = v;
		read_timeout();
	endtask

	task automatic drain();
		edges_ch.valid <= 1'b0;
		while (frames_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin
		frames_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			frames_ch.ready <= calm || $urandom_range(0, 99) >= 16;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && frames_ch.valid === 1'b1 && frames_ch.ready === 1'b1) begin
			if (frames_due.size() == 0) begin
				$error("frame word with none due: address %0h command %0h is_repeat %0b",
					frames_ch.address, frames_ch.command, frames_ch.is_repeat);
				fails++;
			end else begin
				due_word = frames_due.pop_front();
				if (frames_ch.address !== due_word.address) begin
					$error("address: expected %0h, got %0h", due_word.address, frames_ch.address);
					fails++;
				end
				if (frames_ch.command !== due_word.command) begin
					$error("command: expected %0h, got %0h", due_word.command, frames_ch.command);
					fails++;
				end
				if (frames_ch.is_repeat !== due_word.is_repeat) begin
					$error("is_repeat: expected %0b, got %0b", due_word.is_repeat,
						frames_ch.is_repeat);
					fails++;
				end
			end
		end
	end

	initial begin
		int i;
		int p;
		int sel;
		int unsigned base;
		int unsigned next_switch;
		logic [31:0] rd;
		arst_n <= 1'b0;
		edges_ch.valid <= 1'b0;
		edges_ch.cmd <= CMD_EDGE;
		edges_ch.level <= 1'b1;
		edges_ch.now_ticks <= 32'd0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_TIMEOUT;
		pwdata <= 32'd0;
		dec_phase = PH_IDLE;
		dec_last_edge = '0;
		dec_shift = '0;
		dec_count = '0;
		dec_have = 1'b0;
		dec_addr = '0;
		dec_cmd = '0;
		dec_timeout = TIMEOUT_RESET_US;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		read_timeout();

		stamp = 32'hFFFF_FFFE;
		for (i = 0; i < SCRIPT_LEN; i++) begin
			stamp = stamp + script[i].delta;
			send_word(script[i].cmd, script[i].level, stamp, script[i].silent);
		end

		p = 0;
		next_switch = 0;
		base = work_items;
		while (work_items - base < ITEMS) begin
			if (work_items - base >= next_switch) begin
				drain();
				case (p % 5)
				0: set_timeout(16'(TIMEOUT_US_MAX));
				1: set_timeout(16'd0);
				2: set_timeout(16'($urandom_range(1, 3000)));
				3: set_timeout(16'd1);
				default: set_timeout(16'($urandom));
				endcase
				if (p == 0) begin
					apb_xfer(1'b1, ADDR_UNUSED, $urandom, rd);
					read_timeout();
				end
				calm = (p == 2);
				p++;
				next_switch += PHASE_ITEMS;
			end
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				send_frame(frame_bits(), BREAK_NONE, 0);
			end else if (sel < 65) begin
				send_frame(frame_bits(), $urandom_range(0, 1) ? BREAK_WIDTH : BREAK_STALL,
					$urandom_range(0, 65));
			end else if (sel < 85) begin
				start_frame();
				pulse(1'b1, LEAD_LOW_MIN_US, LEAD_LOW_MAX_US, 1'b0);
				pulse(1'b0, REPEAT_MIN_US, REPEAT_MAX_US, $urandom_range(0, 5) == 0);
			end else begin
				repeat ($urandom_range(1, 4))
					send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, 1'b0);
			end
		end
		calm = 1'b0;
		drain();
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* files.f */
rtl/nirfd_pkg.sv
rtl/nirfd_if.sv
rtl/nirfd_cfg.sv
rtl/nirfd_core.sv
rtl/nec_ir_frame_decoder_top.sv
rtl/nirfd_checker.sv
test/nec_ir_frame_decoder_top_tb.sv
